### rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, codes and helper functions for the two-axis stepper block.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    // Datapath sizes
    localparam int POS_WIDTH   = 16;    // step length / step count width
    localparam int DELAY_WIDTH = 6;     // pulse half timer width
    localparam int DELAY_MAX   = (1 << DELAY_WIDTH) - 1;
    localparam int TRAVEL_W    = 15;
    localparam int RAMP_W      = 5;
    localparam int MIN_W       = 5;
    localparam int START_W     = 6;
    localparam int FUNC_W      = 2;
    localparam int VALUE_W     = 16;
    localparam int TGT_W       = VALUE_W + 2;   // position + delta, signed
    localparam int DSUM_W      = 7;             // min_delay + short remainder
    localparam int ERR_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int S_DATA_W    = 32;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 40;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ABS  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;   // handled as a tick

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_X    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_Y    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BUSY = 2'd3;

    // Axis select
    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;

    // Pulse phase
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [1:0] PHASE_LOW  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_TRAVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TRAVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd4;

    // Register reset values
    localparam logic [RAMP_W-1:0]  RAMP_RST  = 5'd13;
    localparam logic [MIN_W-1:0]   MIN_RST   = 5'd7;
    localparam logic [START_W-1:0] START_RST = 6'd20;

    typedef struct packed {
        logic [TRAVEL_W-1:0] x_travel;
        logic [TRAVEL_W-1:0] y_travel;
        logic [RAMP_W-1:0]   ramp_steps;
        logic [MIN_W-1:0]    min_delay;
        logic [START_W-1:0]  start_delay;
    } cfg_t;

    typedef struct packed {
        logic [TRAVEL_W-1:0] pos_y;
        logic [TRAVEL_W-1:0] pos_x;
        logic [ERR_W-1:0]    error_code;
        logic                busy_res;
        logic                enable_y;
        logic                enable_x;
        logic                dir_y;
        logic                dir_x;
        logic                step_y;
        logic                step_x;
    } result_t;

    // Y goes next when it has steps left and X is ahead of it or finished.
    function automatic logic [1:0] pick_axis(
        input logic [POS_WIDTH-1:0] x_cnt,
        input logic [POS_WIDTH-1:0] x_len,
        input logic [POS_WIDTH-1:0] y_cnt,
        input logic [POS_WIDTH-1:0] y_len
    );
        logic [1:0] axis;
        axis = AXIS_NONE;
        if (y_cnt < y_len && (x_cnt > y_cnt || x_cnt >= x_len))
            axis = AXIS_Y;
        else if (x_cnt < x_len)
            axis = AXIS_X;
        return axis;
    endfunction

    // Pulse half length: ramp up, cruise, ramp down; clamped to 1..DELAY_MAX.
    function automatic logic [DELAY_WIDTH-1:0] half_len(
        input logic [POS_WIDTH-1:0] cnt,
        input logic [POS_WIDTH-1:0] len,
        input cfg_t                 cfg
    );
        logic [POS_WIDTH-1:0] left;
        logic [DSUM_W-1:0]    d;
        left = len - cnt;
        if (cnt < POS_WIDTH'(cfg.ramp_steps))
        begin
            if (POS_WIDTH'(cfg.start_delay) > cnt)
                d = DSUM_W'(cfg.start_delay - cnt[START_W-1:0]);
            else
                d = DSUM_W'(1);
        end
        else if (left < POS_WIDTH'(cfg.ramp_steps))
            d = DSUM_W'(cfg.min_delay) + DSUM_W'(left[RAMP_W-1:0]);
        else
            d = DSUM_W'(cfg.min_delay);
        if (d == '0)
            d = DSUM_W'(1);
        if (int'(d) > DELAY_MAX)
            return DELAY_WIDTH'(DELAY_MAX);
        return DELAY_WIDTH'(d);
    endfunction

endpackage

`default_nettype wire

### rtl/stp_cfg_regs.sv
// ----------------------------------------------------------------------------
// stp_cfg_regs
// Configuration register file: travel limits and ramp timing.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_cfg_regs
    import stp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_X_TRAVEL:    cfg_next.x_travel    = cfg_data[TRAVEL_W-1:0];
                REG_Y_TRAVEL:    cfg_next.y_travel    = cfg_data[TRAVEL_W-1:0];
                REG_RAMP_STEPS:  cfg_next.ramp_steps  = cfg_data[RAMP_W-1:0];
                REG_MIN_DELAY:   cfg_next.min_delay   = cfg_data[MIN_W-1:0];
                REG_START_DELAY: cfg_next.start_delay = cfg_data[START_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_travel    <= '0;
            cfg_reg.y_travel    <= '0;
            cfg_reg.ramp_steps  <= RAMP_RST;
            cfg_reg.min_delay   <= MIN_RST;
            cfg_reg.start_delay <= START_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/stp_core.sv
// ----------------------------------------------------------------------------
// stp_core
// Motion state and per-word update: move checks, pulse timing, step counts.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_core
    import stp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [VALUE_W-1:0] x_value,
    input  wire logic signed [VALUE_W-1:0] y_value,
    input  wire cfg_t                      cfg,
    output result_t                        result
);

    logic [TRAVEL_W-1:0]    x_pos_reg, x_pos_next;
    logic [TRAVEL_W-1:0]    y_pos_reg, y_pos_next;
    logic [POS_WIDTH-1:0]   x_len_reg, x_len_next;
    logic [POS_WIDTH-1:0]   y_len_reg, y_len_next;
    logic [POS_WIDTH-1:0]   x_cnt_reg, x_cnt_next;
    logic [POS_WIDTH-1:0]   y_cnt_reg, y_cnt_next;
    logic [1:0]             phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0] timer_reg, timer_next;
    logic [1:0]             dir_reg, dir_next;
    logic                   moving_reg, moving_next;

    logic                    is_move;
    logic signed [TGT_W-1:0] tx, ty, dx, dy, x_abs, y_abs;
    logic [POS_WIDTH-1:0]    move_x_len, move_y_len;
    logic [DELAY_WIDTH-1:0]  timer_dec;
    logic [POS_WIDTH-1:0]    x_cnt_inc, y_cnt_inc;
    logic [1:0]              axis_mv, axis_a, axis_b, axis_o;
    logic [ERR_W-1:0]        err;

    assign is_move = (func == FUNC_REL) || (func == FUNC_ABS);

    // Target and delta in 18-bit signed so absolute moves see no wrap
    always_comb
    begin
        if (func == FUNC_REL)
        begin
            tx = $signed({3'b000, x_pos_reg}) + TGT_W'(x_value);
            ty = $signed({3'b000, y_pos_reg}) + TGT_W'(y_value);
        end
        else
        begin
            tx = TGT_W'(x_value);
            ty = TGT_W'(y_value);
        end
        dx = tx - $signed({3'b000, x_pos_reg});
        dy = ty - $signed({3'b000, y_pos_reg});
        x_abs = (dx < 0) ? -dx : dx;
        y_abs = (dy < 0) ? -dy : dy;
        move_x_len = x_abs[POS_WIDTH-1:0];
        move_y_len = y_abs[POS_WIDTH-1:0];
    end

    assign timer_dec = (timer_reg != '0) ? timer_reg - DELAY_WIDTH'(1) : timer_reg;
    assign axis_mv   = pick_axis('0, move_x_len, '0, move_y_len);
    assign axis_a    = pick_axis(x_cnt_reg, x_len_reg, y_cnt_reg, y_len_reg);
    assign x_cnt_inc = (axis_a == AXIS_X) ? x_cnt_reg + POS_WIDTH'(1) : x_cnt_reg;
    assign y_cnt_inc = (axis_a == AXIS_Y) ? y_cnt_reg + POS_WIDTH'(1) : y_cnt_reg;
    assign axis_b    = pick_axis(x_cnt_inc, x_len_reg, y_cnt_inc, y_len_reg);

    always_comb
    begin
        x_pos_next  = x_pos_reg;
        y_pos_next  = y_pos_reg;
        x_len_next  = x_len_reg;
        y_len_next  = y_len_reg;
        x_cnt_next  = x_cnt_reg;
        y_cnt_next  = y_cnt_reg;
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        dir_next    = dir_reg;
        moving_next = moving_reg;
        err         = ERR_NONE;

        if (item_valid && is_move)
        begin
            if (moving_reg)
                err = ERR_BUSY;
            else if (tx < 0 || tx > $signed({3'b000, cfg.x_travel}))
                err = ERR_X;
            else if (ty < 0 || ty > $signed({3'b000, cfg.y_travel}))
                err = ERR_Y;
            else
            begin
                // zero delta keeps the pin level
                if (dx > 0) dir_next[0] = 1'b1;
                if (dx < 0) dir_next[0] = 1'b0;
                if (dy > 0) dir_next[1] = 1'b1;
                if (dy < 0) dir_next[1] = 1'b0;
                x_len_next = move_x_len;
                y_len_next = move_y_len;
                x_cnt_next = '0;
                y_cnt_next = '0;
                x_pos_next = tx[TRAVEL_W-1:0];
                y_pos_next = ty[TRAVEL_W-1:0];
                if (axis_mv != AXIS_NONE)
                begin
                    moving_next = 1'b1;
                    phase_next  = PHASE_HIGH;
                    timer_next  = (axis_mv == AXIS_X) ? half_len('0, move_x_len, cfg)
                                                      : half_len('0, move_y_len, cfg);
                end
                else
                begin
                    moving_next = 1'b0;
                    phase_next  = PHASE_IDLE;
                    timer_next  = '0;
                end
            end
        end
        else if (item_valid && moving_reg)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                if (phase_reg == PHASE_HIGH && axis_a != AXIS_NONE)
                begin
                    phase_next = PHASE_LOW;
                    timer_next = (axis_a == AXIS_X) ? half_len(x_cnt_reg, x_len_reg, cfg)
                                                    : half_len(y_cnt_reg, y_len_reg, cfg);
                end
                else
                begin
                    // end of low half: count the step, pick who goes next
                    x_cnt_next = x_cnt_inc;
                    y_cnt_next = y_cnt_inc;
                    if (axis_b != AXIS_NONE)
                    begin
                        phase_next = PHASE_HIGH;
                        timer_next = (axis_b == AXIS_X) ? half_len(x_cnt_inc, x_len_reg, cfg)
                                                        : half_len(y_cnt_inc, y_len_reg, cfg);
                    end
                    else
                    begin
                        moving_next = 1'b0;
                        phase_next  = PHASE_IDLE;
                        timer_next  = '0;
                    end
                end
            end
        end
    end

    assign axis_o = moving_next ? pick_axis(x_cnt_next, x_len_next, y_cnt_next, y_len_next)
                                : AXIS_NONE;

    always_comb
    begin
        result.step_x     = (phase_next == PHASE_HIGH) && (axis_o == AXIS_X);
        result.step_y     = (phase_next == PHASE_HIGH) && (axis_o == AXIS_Y);
        result.dir_x      = dir_next[0];
        result.dir_y      = dir_next[1];
        result.enable_x   = moving_next && (x_cnt_next < x_len_next);
        result.enable_y   = moving_next && (y_cnt_next < y_len_next);
        result.busy_res   = moving_next;
        result.error_code = err;
        result.pos_x      = x_pos_next;
        result.pos_y      = y_pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg  <= '0;
            y_pos_reg  <= '0;
            x_len_reg  <= '0;
            y_len_reg  <= '0;
            x_cnt_reg  <= '0;
            y_cnt_reg  <= '0;
            phase_reg  <= PHASE_IDLE;
            timer_reg  <= '0;
            dir_reg    <= '0;
            moving_reg <= 1'b0;
        end
        else if (item_valid)
        begin
            x_pos_reg  <= x_pos_next;
            y_pos_reg  <= y_pos_next;
            x_len_reg  <= x_len_next;
            y_len_reg  <= y_len_next;
            x_cnt_reg  <= x_cnt_next;
            y_cnt_reg  <= y_cnt_next;
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            dir_reg    <= dir_next;
            moving_reg <= moving_next;
        end
    end

endmodule

`default_nettype wire

### rtl/two_axis_stepper_move_ramp_top.sv
// Throughput: one word per cycle unless the output stalls; input register,
//   single-pass state update, output register. Output stalls back up
//   through the input register.
// Reset: asynchronous, active low; clears motion state and positions,
//   loads ramp 13, cruise delay 7, start delay 20, travel limits 0.
// ----------------------------------------------------------------------------
// two_axis_stepper_move_ramp_top
// Two-axis step/direction generator with linear speed ramp, stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_stepper_move_ramp_top
    import stp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // x_value[15:0], y_value[31:16]
    input  wire logic [S_USER_W-1:0]   s_tuser,   // func[1:0]
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata    // step_x, step_y, dir_x, dir_y,
                                                  // enable_x, enable_y, busy_res,
                                                  // error_code[8:7], pos_x[23:9],
                                                  // pos_y[38:24], zero[39]
);

    cfg_t    cfg;
    result_t core_res;

    logic                      in_valid_reg, in_valid_next;
    logic [FUNC_W-1:0]         in_func_reg;
    logic signed [VALUE_W-1:0] in_x_reg, in_y_reg;
    logic                      out_valid_reg, out_valid_next;
    result_t                   res_reg;
    logic                      advance, s_accept;

    stp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .func       (in_func_reg),
        .x_value    (in_x_reg),
        .y_value    (in_y_reg),
        .cfg        (cfg),
        .result     (core_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg <= s_tuser[FUNC_W-1:0];
            in_x_reg    <= s_tdata[VALUE_W-1:0];
            in_y_reg    <= s_tdata[2*VALUE_W-1:VALUE_W];
        end
        if (advance)
            res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

endmodule

`default_nettype wire
